@@ rtl/core/icl_pkg.sv @@
package icl_pkg;

	localparam int OP_W        = 3;
	localparam int INDEX_W     = 16;
	localparam int VALUE_W     = 32;
	localparam int STATUS_W    = 2;
	localparam int COUNT_OUT_W = 7;

	localparam logic [OP_W-1:0] OP_APPEND  = 3'd0;
	localparam logic [OP_W-1:0] OP_INSERT  = 3'd1;
	localparam logic [OP_W-1:0] OP_REMOVE  = 3'd2;
	localparam logic [OP_W-1:0] OP_READ    = 3'd3;
	localparam logic [OP_W-1:0] OP_REVERSE = 3'd4;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]    operation;
		logic [INDEX_W-1:0] index;
		logic [VALUE_W-1:0] token_value;
	} icl_cmd_t;

	typedef struct packed {
		logic [VALUE_W-1:0]     read_value;
		logic [STATUS_W-1:0]    status;
		logic [COUNT_OUT_W-1:0] entry_count;
	} icl_res_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MOD,
		S_INS,
		S_PUT,
		S_REM,
		S_RD,
		S_RDW,
		S_REV_A,
		S_REV_B,
		S_REV_C,
		S_REV_D,
		S_RESP
	} state_t;

endpackage

@@ rtl/core/icl_ram.sv @@
module icl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/core/icl_mod.sv @@
module icl_mod
	import icl_pkg::*;
#(
	parameter int DW = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  logic [INDEX_W-1:0] dividend,
	input  logic [DW-1:0]      divisor,
	output logic               done,
	output logic [DW-1:0]      remainder
);

	localparam int SW = $clog2(INDEX_W);

	logic               run_q;
	logic               done_q;
	logic [SW-1:0]      step_q;
	logic [INDEX_W-1:0] dvd_q;
	logic [DW-1:0]      dsr_q;
	logic [DW-1:0]      rem_q;
	logic [DW:0]        part;
	logic [DW:0]        diff;
	logic [DW-1:0]      rem_next;

	always_comb begin
		part     = {rem_q, dvd_q[INDEX_W-1]};
		diff     = part - {1'b0, dsr_q};
		rem_next = (part >= {1'b0, dsr_q}) ? diff[DW-1:0] : part[DW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + SW'(1);
				if (step_q == SW'(INDEX_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[INDEX_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

@@ rtl/core/indexed_circular_list_unit.sv @@
// Channel   Ports                  Transfer condition
// command   start, busy, cmd       start high and busy low at a rising edge
// result    done, result           done high for one cycle, always taken
//
// Insert, remove and read first reduce the index with the 16-step
// remainder unit. Insert and remove then shift entries, with one read and
// one write of the entry RAM per move. Reverse reads the lower and upper entry
// of each swapped pair, then writes both, all on the single RAM port pair.
// Reset clears the count and control; the entry RAM is not cleared.
// The result cannot be stalled; busy stays high until the result cycle ends.
module indexed_circular_list_unit
	import icl_pkg::*;
#(
	parameter int DEPTH       = 64,
	parameter int TOKEN_WIDTH = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  icl_cmd_t cmd,
	output logic     done,
	output icl_res_t result
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	state_t state_q;
	state_t state_d;

	logic [CW-1:0]          count_q;
	logic                   wv_s1;
	logic [AW-1:0]          waddr_s1;
	logic [OP_W-1:0]        op_q;
	logic [TOKEN_WIDTH-1:0] tok_q;
	logic [TOKEN_WIDTH-1:0] tmp_q;
	logic [VALUE_W-1:0]     value_q;
	logic [STATUS_W-1:0]    status_q;
	logic [CW-1:0]          cur_q;
	logic [CW-1:0]          pos_q;
	logic [CW-1:0]          lo_q;
	logic [CW-1:0]          hi_q;

	logic                   accept;
	logic                   full;
	logic                   empty;
	logic                   mod_go;
	logic                   mod_done;
	logic [CW-1:0]          mod_divisor;
	logic [CW-1:0]          mod_rem;
	logic                   ins_more;
	logic                   rem_more;
	logic                   rev_more;
	logic [STATUS_W-1:0]    status_d;

	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [TOKEN_WIDTH-1:0] ram_wdata;
	logic                   ram_re;
	logic [AW-1:0]          ram_raddr;
	logic [TOKEN_WIDTH-1:0] ram_rdata;

	assign accept   = start && (state_q == S_IDLE);
	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign ins_more = (cur_q > pos_q);
	assign rem_more = ((cur_q + CW'(1)) < count_q);
	assign rev_more = ((lo_q + CW'(2)) < hi_q);

	assign mod_go = accept && (((cmd.operation == OP_INSERT) && !full) ||
		(((cmd.operation == OP_REMOVE) || (cmd.operation == OP_READ)) && !empty));
	assign mod_divisor = (cmd.operation == OP_INSERT) ? (count_q + CW'(1)) : count_q;

	always_comb begin
		status_d = STATUS_OK;
		case (cmd.operation) inside
			OP_APPEND, OP_INSERT: begin
				if (full) begin
					status_d = STATUS_FULL;
				end
			end
			OP_REMOVE, OP_READ, OP_REVERSE: begin
				if (empty) begin
					status_d = STATUS_EMPTY;
				end
			end
			default: begin
				status_d = STATUS_OK;
			end
		endcase
	end

	icl_mod #(
		.DW (CW)
	) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (mod_go),
		.dividend  (cmd.index),
		.divisor   (mod_divisor),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	icl_ram #(
		.WIDTH (TOKEN_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (cmd.operation)
						OP_APPEND:  state_d = full ? S_RESP : S_INS;
						OP_INSERT:  state_d = full ? S_RESP : S_MOD;
						OP_REMOVE:  state_d = empty ? S_RESP : S_MOD;
						OP_READ:    state_d = empty ? S_RESP : S_MOD;
						OP_REVERSE: state_d = (count_q < CW'(2)) ? S_RESP : S_REV_A;
						default:    state_d = S_RESP;
					endcase
				end
			end
			S_MOD: begin
				if (mod_done) begin
					unique case (op_q)
						OP_INSERT: state_d = S_INS;
						OP_REMOVE: state_d = S_REM;
						OP_READ:   state_d = S_RD;
						default:   state_d = S_RESP;
					endcase
				end
			end
			S_INS:   state_d = ins_more ? S_INS : S_PUT;
			S_PUT:   state_d = S_RESP;
			S_REM:   state_d = rem_more ? S_REM : S_RESP;
			S_RD:    state_d = S_RDW;
			S_RDW:   state_d = S_RESP;
			S_REV_A: state_d = S_REV_B;
			S_REV_B: state_d = S_REV_C;
			S_REV_C: state_d = S_REV_D;
			S_REV_D: state_d = rev_more ? S_REV_A : S_RESP;
			S_RESP:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = '0;
		ram_we    = 1'b0;
		ram_waddr = waddr_s1;
		ram_wdata = ram_rdata;
		unique case (state_q)
			S_INS: begin
				ram_re    = ins_more;
				ram_raddr = AW'(cur_q - CW'(1));
			end
			S_REM: begin
				ram_re    = rem_more;
				ram_raddr = AW'(cur_q + CW'(1));
			end
			S_RD: begin
				ram_re    = 1'b1;
				ram_raddr = pos_q[AW-1:0];
			end
			S_REV_A: begin
				ram_re    = 1'b1;
				ram_raddr = lo_q[AW-1:0];
			end
			S_REV_B: begin
				ram_re    = 1'b1;
				ram_raddr = hi_q[AW-1:0];
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
		if (wv_s1) begin
			ram_we = 1'b1;
		end else begin
			unique case (state_q)
				S_PUT: begin
					ram_we    = 1'b1;
					ram_waddr = pos_q[AW-1:0];
					ram_wdata = tok_q;
				end
				S_REV_C: begin
					ram_we    = 1'b1;
					ram_waddr = lo_q[AW-1:0];
				end
				S_REV_D: begin
					ram_we    = 1'b1;
					ram_waddr = hi_q[AW-1:0];
					ram_wdata = tmp_q;
				end
				default: begin
					ram_we = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			wv_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			wv_s1   <= ((state_q == S_INS) && ins_more) || ((state_q == S_REM) && rem_more);
			if (state_q == S_PUT) begin
				count_q <= count_q + CW'(1);
			end else if ((state_q == S_REM) && !rem_more) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		waddr_s1 <= cur_q[AW-1:0];
		if (accept) begin
			op_q     <= cmd.operation;
			tok_q    <= TOKEN_WIDTH'(cmd.token_value);
			value_q  <= '0;
			status_q <= status_d;
			cur_q    <= count_q;
			pos_q    <= count_q;
			lo_q     <= '0;
			hi_q     <= count_q - CW'(1);
		end
		if ((state_q == S_MOD) && mod_done) begin
			pos_q <= mod_rem;
			cur_q <= (op_q == OP_INSERT) ? count_q : mod_rem;
		end
		if ((state_q == S_INS) && ins_more) begin
			cur_q <= cur_q - CW'(1);
		end
		if ((state_q == S_REM) && rem_more) begin
			cur_q <= cur_q + CW'(1);
		end
		if (state_q == S_RDW) begin
			value_q <= VALUE_W'(ram_rdata);
		end
		if (state_q == S_REV_B) begin
			tmp_q <= ram_rdata;
		end
		if (state_q == S_REV_D) begin
			lo_q <= lo_q + CW'(1);
			hi_q <= hi_q - CW'(1);
		end
	end

	assign busy               = (state_q != S_IDLE);
	assign done               = (state_q == S_RESP);
	assign result.read_value  = value_q;
	assign result.status      = status_q;
	assign result.entry_count = COUNT_OUT_W'(count_q);

endmodule
